// File: hw/rtl/pbp_pkg.sv
package pbp_pkg;

    localparam int MAX_INTERFACES = 16;

    localparam logic [31:0] SHB_TYPE   = 32'h0A0D_0D0A;
    localparam logic [31:0] IDB_TYPE   = 32'h0000_0001;
    localparam logic [31:0] EPB_TYPE   = 32'h0000_0006;
    localparam logic [31:0] BOM_LITTLE = 32'h1A2B_3C4D;
    localparam logic [31:0] BOM_BIG    = 32'h4D3C_2B1A;

    localparam logic [31:0] HDR_LEN   = 32'd12;
    localparam logic [31:0] SHB_MIN   = 32'd28;
    localparam logic [31:0] IDB_MIN   = 32'd20;
    localparam logic [31:0] EPB_MIN   = 32'd32;
    localparam logic [31:0] WORD_LEN  = 32'd4;
    localparam logic [31:0] EPB_FIXED = 32'd28;

    localparam logic [31:0] HDR_LAST_POS = 32'd11;
    localparam logic [31:0] FIELD_START  = 32'd8;
    localparam logic [31:0] FIELD_END    = 32'd28;
    localparam logic [31:0] LEN_START    = 32'd4;

    localparam logic [0:0] REG_FILE_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_SHORT_HDR    = 4'd1,
        ST_BIG_ENDIAN   = 4'd2,
        ST_BAD_MAGIC    = 4'd3,
        ST_NO_SECTION   = 4'd4,
        ST_BAD_LENGTH   = 4'd5,
        ST_PAST_END     = 4'd6,
        ST_CLOSE_MISM   = 4'd7,
        ST_SHB_SMALL    = 4'd8,
        ST_IDB_SMALL    = 4'd9,
        ST_EPB_SMALL    = 4'd10,
        ST_CAP_OVER     = 4'd11,
        ST_DATA_PAST    = 4'd12
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] blk_kind;
        logic [63:0] blk_offset;
        logic [31:0] block_length;
        logic [31:0] if_id;
        logic [15:0] link_code;
        logic [31:0] snap_length;
        logic        if_found;
        logic [63:0] timestamp;
        logic [31:0] cap_len;
        logic [31:0] orig_len;
        logic [63:0] pkt_seq;
    } result_t;

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = (lane == 2'd0) ? 32'(b) : (w | (32'(b) << {lane, 3'b000}));
        return r;
    endfunction

endpackage

// File: hw/rtl/pbp_in_if.sv
interface pbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// File: hw/rtl/pbp_out_if.sv
interface pbp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] blk_kind;
    logic [63:0] blk_offset;
    logic [31:0] block_length;
    logic [31:0] if_id;
    logic [15:0] link_code;
    logic [31:0] snap_length;
    logic        if_found;
    logic [63:0] timestamp;
    logic [31:0] cap_len;
    logic [31:0] orig_len;
    logic [63:0] pkt_seq;

    modport source (output valid, output status, output blk_kind, output blk_offset,
                    output block_length, output if_id, output link_code,
                    output snap_length, output if_found, output timestamp,
                    output cap_len, output orig_len, output pkt_seq,
                    input ready);
    modport sink (input valid, input status, input blk_kind, input blk_offset,
                  input block_length, input if_id, input link_code,
                  input snap_length, input if_found, input timestamp,
                  input cap_len, input orig_len, input pkt_seq,
                  output ready);
endinterface

// File: hw/rtl/pbp_ram.sv
module pbp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// File: hw/rtl/pbp_cfg.sv
module pbp_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] file_length
);

    logic [63:0] file_length_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[3] == pbp_pkg::REG_FILE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (wr)
        begin
            file_length_reg <= pwdata;
        end
    end

    assign prdata = (paddr[3] == pbp_pkg::REG_FILE_LENGTH) ? file_length_reg : 64'd0;
    assign file_length = file_length_reg;

endmodule

// File: hw/rtl/pbp_parser.sv
module pbp_parser #(
    parameter int MAX_IF = pbp_pkg::MAX_INTERFACES,
    parameter int AW = (MAX_IF > 1) ? $clog2(MAX_IF) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic [63:0]         file_length,
    output logic                res_valid,
    output pbp_pkg::result_t    res
);

    logic [63:0] byte_offset_reg, block_start_reg, packet_counter_reg;
    logic [31:0] pos_reg, type_reg, len_reg, icount_reg;
    logic [31:0] fw_reg [6];
    logic [31:0] fw_next [6];
    logic        section_reg, err_reg;

    logic [31:0] p, type_next, len_next, pm8, cap, orig;
    logic [1:0]  lane;
    logic        start, at_end, short_hdr, hdr_at, fin_at, hdr_fail, fin_fail, proceed;
    logic [63:0] bs, rem;
    logic [33:0] need;
    pbp_pkg::status_t hdr_st, fin_st;
    logic        known, wr_en;
    logic [47:0] rd_data;

    assign p      = pos_reg;
    assign lane   = p[1:0];
    assign start  = (p == 32'd0);
    assign at_end = byte_offset_reg >= file_length;
    assign bs     = start ? byte_offset_reg : block_start_reg;
    assign short_hdr = start && ((file_length - byte_offset_reg) < 64'(pbp_pkg::HDR_LEN));
    assign proceed = step && !err_reg && !(start && at_end) && !short_hdr;
    assign pm8 = p - pbp_pkg::FIELD_START;

    always_comb
    begin
        type_next = type_reg;
        len_next = len_reg;
        for (int i = 0; i < 6; i++)
        begin
            fw_next[i] = fw_reg[i];
        end
        if (p < pbp_pkg::LEN_START)
        begin
            type_next = pbp_pkg::put_byte(type_reg, lane, data_byte);
        end
        else if (p < pbp_pkg::FIELD_START)
        begin
            len_next = pbp_pkg::put_byte(len_reg, lane, data_byte);
        end
        else
        begin
            if (p < pbp_pkg::FIELD_END)
            begin
                fw_next[pm8[4:2]] = pbp_pkg::put_byte(fw_reg[pm8[4:2]], lane, data_byte);
            end
            if (p >= len_reg - pbp_pkg::WORD_LEN)
            begin
                fw_next[5] = pbp_pkg::put_byte(fw_reg[5], lane, data_byte);
            end
        end
    end

    assign rem = (block_start_reg < file_length) ? (file_length - block_start_reg) : 64'd0;
    assign hdr_at = (p == pbp_pkg::HDR_LAST_POS);

    always_comb
    begin
        hdr_fail = 1'b1;
        hdr_st = pbp_pkg::ST_OK;
        if ((type_reg == pbp_pkg::SHB_TYPE) && (fw_next[0] == pbp_pkg::BOM_BIG))
        begin
            hdr_st = pbp_pkg::ST_BIG_ENDIAN;
        end
        else if ((type_reg == pbp_pkg::SHB_TYPE) && (fw_next[0] != pbp_pkg::BOM_LITTLE))
        begin
            hdr_st = pbp_pkg::ST_BAD_MAGIC;
        end
        else if ((type_reg != pbp_pkg::SHB_TYPE) && !section_reg)
        begin
            hdr_st = pbp_pkg::ST_NO_SECTION;
        end
        else if ((len_reg < pbp_pkg::HDR_LEN) || (len_reg[1:0] != 2'd0))
        begin
            hdr_st = pbp_pkg::ST_BAD_LENGTH;
        end
        else if (64'(len_reg) > rem)
        begin
            hdr_st = pbp_pkg::ST_PAST_END;
        end
        else
        begin
            hdr_fail = 1'b0;
        end
    end

    assign fin_at = (p >= pbp_pkg::HDR_LAST_POS) && (p == len_reg - 32'd1);
    assign cap  = fw_next[3];
    assign orig = fw_next[4];
    assign need = 34'(pbp_pkg::EPB_FIXED) + ((34'(cap) + 34'd3) & ~34'd3)
                  + 34'(pbp_pkg::WORD_LEN);

    always_comb
    begin
        fin_fail = 1'b1;
        fin_st = pbp_pkg::ST_OK;
        if (fw_next[5] != len_reg)
        begin
            fin_st = pbp_pkg::ST_CLOSE_MISM;
        end
        else if ((type_reg == pbp_pkg::SHB_TYPE) && (len_reg < pbp_pkg::SHB_MIN))
        begin
            fin_st = pbp_pkg::ST_SHB_SMALL;
        end
        else if ((type_reg == pbp_pkg::IDB_TYPE) && (len_reg < pbp_pkg::IDB_MIN))
        begin
            fin_st = pbp_pkg::ST_IDB_SMALL;
        end
        else if ((type_reg == pbp_pkg::EPB_TYPE) && (len_reg < pbp_pkg::EPB_MIN))
        begin
            fin_st = pbp_pkg::ST_EPB_SMALL;
        end
        else if ((type_reg == pbp_pkg::EPB_TYPE) && (cap > orig))
        begin
            fin_st = pbp_pkg::ST_CAP_OVER;
        end
        else if ((type_reg == pbp_pkg::EPB_TYPE) && (need > 34'(len_reg)))
        begin
            fin_st = pbp_pkg::ST_DATA_PAST;
        end
        else
        begin
            fin_fail = 1'b0;
        end
    end

    assign known = (fw_next[0] < icount_reg) && (fw_next[0] < 32'(MAX_IF));
    assign wr_en = proceed && !(hdr_at && hdr_fail) && fin_at && !fin_fail
                   && (type_reg == pbp_pkg::IDB_TYPE) && (icount_reg < 32'(MAX_IF));

    pbp_ram #(.WIDTH(48), .DEPTH(MAX_IF), .AW(AW)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (icount_reg[AW-1:0]),
        .wr_data ({fw_next[0][15:0], fw_next[1]}),
        .rd_addr (fw_reg[0][AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        res = '0;
        res_valid = 1'b0;
        res.blk_offset = bs;
        if (step && !err_reg && !(start && at_end))
        begin
            if (short_hdr)
            begin
                res_valid = 1'b1;
                res.status = pbp_pkg::ST_SHORT_HDR;
            end
            else if (hdr_at && hdr_fail)
            begin
                res_valid = 1'b1;
                res.status = hdr_st;
            end
            else if (fin_at && fin_fail)
            begin
                res_valid = 1'b1;
                res.status = fin_st;
            end
            else if (fin_at)
            begin
                res_valid = 1'b1;
                res.blk_kind = type_reg;
                res.block_length = len_reg;
                if (type_reg == pbp_pkg::IDB_TYPE)
                begin
                    res.if_id = icount_reg;
                    res.link_code = fw_next[0][15:0];
                    res.snap_length = fw_next[1];
                end
                else if (type_reg == pbp_pkg::EPB_TYPE)
                begin
                    res.if_id = fw_next[0];
                    res.link_code = known ? rd_data[47:32] : 16'd0;
                    res.if_found = known;
                    res.timestamp = {fw_next[1], fw_next[2]};
                    res.cap_len = cap;
                    res.orig_len = orig;
                    res.pkt_seq = packet_counter_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            block_start_reg <= '0;
            packet_counter_reg <= '0;
            pos_reg <= '0;
            type_reg <= '0;
            len_reg <= '0;
            icount_reg <= '0;
            section_reg <= 1'b0;
            err_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                fw_reg[i] <= '0;
            end
        end
        else if (step && !err_reg && !(start && at_end))
        begin
            block_start_reg <= bs;
            if (short_hdr)
            begin
                err_reg <= 1'b1;
            end
            else
            begin
                byte_offset_reg <= byte_offset_reg + 64'd1;
                type_reg <= type_next;
                len_reg <= len_next;
                for (int i = 0; i < 6; i++)
                begin
                    fw_reg[i] <= fw_next[i];
                end
                if ((hdr_at && hdr_fail) || (fin_at && fin_fail))
                begin
                    err_reg <= 1'b1;
                end
                else if (fin_at)
                begin
                    pos_reg <= '0;
                    if (type_reg == pbp_pkg::SHB_TYPE)
                    begin
                        section_reg <= 1'b1;
                        icount_reg <= '0;
                    end
                    else if (type_reg == pbp_pkg::IDB_TYPE)
                    begin
                        if (icount_reg != 32'hFFFF_FFFF)
                        begin
                            icount_reg <= icount_reg + 32'd1;
                        end
                    end
                    else if (type_reg == pbp_pkg::EPB_TYPE)
                    begin
                        packet_counter_reg <= packet_counter_reg + 64'd1;
                    end
                end
                else
                begin
                    pos_reg <= p + 32'd1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/pcapng_block_parser.sv
// A result word is registered and appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle, also in the cycle in which a held result word leaves.
// The block stalls input only while a result is held and the output is not ready.
// Reset (rst_n, asynchronous, active low) clears counters, flags and the file length.
// The interface table holds no reset value; it is written by interface blocks only.
module pcapng_block_parser #(
    parameter int MAX_INTERFACES = pbp_pkg::MAX_INTERFACES
) (
    input  logic        clk,
    input  logic        rst_n,
    pbp_in_if.sink      in_ch,
    pbp_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]      file_length;
    logic             step, res_valid, out_valid_reg;
    pbp_pkg::result_t res, out_reg;

    pbp_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .file_length (file_length)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;

    pbp_parser #(.MAX_IF(MAX_INTERFACES)) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_ch.data_byte),
        .file_length (file_length),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_reg.status;
    assign out_ch.blk_kind     = out_reg.blk_kind;
    assign out_ch.blk_offset   = out_reg.blk_offset;
    assign out_ch.block_length = out_reg.block_length;
    assign out_ch.if_id        = out_reg.if_id;
    assign out_ch.link_code    = out_reg.link_code;
    assign out_ch.snap_length  = out_reg.snap_length;
    assign out_ch.if_found     = out_reg.if_found;
    assign out_ch.timestamp    = out_reg.timestamp;
    assign out_ch.cap_len      = out_reg.cap_len;
    assign out_ch.orig_len     = out_reg.orig_len;
    assign out_ch.pkt_seq      = out_reg.pkt_seq;

endmodule
